FILE: sv/tqr_pkg.sv
`default_nettype none

package tqr_pkg;

  localparam int unsigned IV_W       = 16;
  localparam int unsigned DUR_W      = 9;
  localparam int unsigned QL_W       = 28;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned TEMPO_W    = 16;
  localparam int unsigned BPM_W      = 10;
  localparam int unsigned DIV_W      = 41;
  localparam int unsigned NB_W       = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned MS_PER_MIN = 60000;

  localparam logic [CFG_IDX_W-1:0] CFG_DOTTED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET = 2'd2;

  localparam logic [DUR_W-1:0]   DUR_WHOLE   = 9'd480;
  localparam logic [DUR_W-1:0]   DUR_MIN     = 9'd15;
  localparam logic [2:0]         CLASS_LAST  = 3'd5;
  localparam logic [BPM_W-1:0]   BPM_RESET   = 10'd120;
  localparam logic [QL_W-1:0]    QL_MAX      = '1;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PRESET,
    ST_CLASS,
    ST_SAMPLE_GO,
    ST_SAMPLE,
    ST_MEAN_GO,
    ST_MEAN,
    ST_TEMPO_GO,
    ST_TEMPO,
    ST_DONE
  } tqr_state_e;

  typedef struct packed {
    logic             start;
    logic [NB_W-1:0]  nbits;
    logic [DIV_W-1:0] dividend;
    logic [QL_W-1:0]  divisor;
  } tqr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } tqr_div_rsp_t;

  function automatic logic [QL_W-1:0] sat_ql(input logic [DIV_W-1:0] v);
    return (v > DIV_W'(QL_MAX)) ? QL_MAX : v[QL_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/tqr_if.sv
`default_nettype none

interface tqr_in_if;
  logic                      valid;
  logic                      ready;
  logic [tqr_pkg::IV_W-1:0]  interval_ms;
  logic                      first_of_take;

  modport source (output valid, output interval_ms, output first_of_take, input ready);
  modport sink   (input valid, input interval_ms, input first_of_take, output ready);
endinterface

interface tqr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tqr_pkg::DUR_W-1:0]   duration_ticks;
  logic [tqr_pkg::QL_W-1:0]    quarter_estimate_q8;
  logic [tqr_pkg::TEMPO_W-1:0] tempo_bpm;

  modport source (output valid, output duration_ticks, output quarter_estimate_q8,
                  output tempo_bpm, input ready);
  modport sink   (input valid, input duration_ticks, input quarter_estimate_q8,
                  input tempo_bpm, output ready);
endinterface

`default_nettype wire

FILE: sv/tqr_div.sv
`default_nettype none

module tqr_div (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  tqr_pkg::tqr_div_req_t req_i,
  output tqr_pkg::tqr_div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [tqr_pkg::NB_W-1:0]     cnt_q, cnt_d;
  logic [tqr_pkg::DIV_W-1:0]    dvd_q, dvd_d;
  logic [tqr_pkg::DIV_W-1:0]    quo_q, quo_d;
  logic [tqr_pkg::QL_W-1:0]     rem_q, rem_d;
  logic [tqr_pkg::QL_W-1:0]     dsr_q, dsr_d;
  logic [tqr_pkg::QL_W:0]       rem_sh;
  logic [tqr_pkg::QL_W:0]       diff;
  logic                         ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[tqr_pkg::DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      dvd_d  = req_i.dividend << (tqr_pkg::NB_W'(tqr_pkg::DIV_W) - req_i.nbits);
      quo_d  = '0;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[tqr_pkg::QL_W-1:0] : rem_sh[tqr_pkg::QL_W-1:0];
      quo_d = {quo_q[tqr_pkg::DIV_W-2:0], ge};
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tqr_pkg::NB_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: sv/tap_rhythm_quantizer.sv
// Tap rhythm quantizer: each accepted word carries a tap interval in ms and a flag that
// starts a new take; the block returns one word with the quantized duration in ticks
// (480 per whole note), the running quarter-note estimate in ms with FRAC_BITS fraction
// bits, and the tempo it implies. The user must write configuration only while the block
// is idle; the block itself does not enforce it. Work on a word is serial: up to four
// divisions on one shared restoring divider that yields one quotient bit per cycle (the
// preset quarter at the start of a take with auto mode off, before a threshold search of
// up to six steps, then sample, running mean and tempo). Input ready is low while a word
// is worked on. A finished result waits in the output register while the next word is
// accepted.
`default_nettype none

module tap_rhythm_quantizer #(
  parameter int unsigned MAX_TAPS  = 1024,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  tqr_in_if.sink                            in_i,
  tqr_out_if.source                         out_o,
  input  wire                               cfg_we_i,
  input  wire  [tqr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [tqr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_TAPS + 1);
  localparam int unsigned T_W   = tqr_pkg::IV_W + FRAC_BITS;
  localparam int unsigned CMP_W = (T_W + 6 > tqr_pkg::QL_W + 3) ? T_W + 6 : tqr_pkg::QL_W + 3;
  localparam int unsigned DW    = tqr_pkg::DIV_W;
  localparam logic [tqr_pkg::NB_W-1:0] NB_NUM    = tqr_pkg::NB_W'(T_W);
  localparam logic [tqr_pkg::NB_W-1:0] NB_SAMPLE = tqr_pkg::NB_W'(T_W + 7);
  localparam logic [tqr_pkg::NB_W-1:0] NB_MEAN   = tqr_pkg::NB_W'(DW);
  localparam logic [DW-1:0] TEMPO_NUM = DW'(tqr_pkg::MS_PER_MIN) << FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TAPS);

  tqr_pkg::tqr_state_e state_q, state_d;

  logic                          dotted_q, dotted_d;
  logic                          auto_q, auto_d;
  logic [tqr_pkg::BPM_W-1:0]     bpm_q, bpm_d;
  logic [tqr_pkg::QL_W-1:0]      ql_q, ql_d;
  logic [tqr_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          ov_q, ov_d;

  logic [T_W-1:0]                t_q, t_d;
  logic                          first_q, first_d;
  logic [CMP_W-1:0]              ts_q, ts_d;
  logic [tqr_pkg::DUR_W-1:0]     trial_q, trial_d;
  logic [2:0]                    k_q, k_d;
  logic [tqr_pkg::DUR_W-1:0]     dur_q, dur_d;
  logic [tqr_pkg::TEMPO_W-1:0]   tempo_q, tempo_d;
  logic [tqr_pkg::DUR_W-1:0]     o_dur_q, o_dur_d;
  logic [tqr_pkg::QL_W-1:0]      o_ql_q, o_ql_d;
  logic [tqr_pkg::TEMPO_W-1:0]   o_tempo_q, o_tempo_d;

  tqr_pkg::tqr_div_req_t         div_req;
  tqr_pkg::tqr_div_rsp_t         div_rsp;

  logic [CMP_W-1:0]              ql_ext, ql5, ql6, ql7, plain_lim;
  logic                          hit_plain, hit_dot;
  logic [tqr_pkg::DUR_W+1:0]     trial3;
  logic [tqr_pkg::BPM_W-1:0]     bpm_eff;
  logic [tqr_pkg::QL_W-1:0]      q_sat;
  logic [tqr_pkg::SUM_W:0]       sum_add;
  logic [tqr_pkg::TEMPO_W-1:0]   tempo_sat;

  tqr_div u_tqr_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    ql_ext    = CMP_W'(ql_q);
    ql5       = (ql_ext << 2) + ql_ext;
    ql6       = (ql_ext << 2) + (ql_ext << 1);
    ql7       = (ql_ext << 3) - ql_ext;
    plain_lim = dotted_q ? ql7 : ql6;
    hit_plain = ts_q > plain_lim;
    hit_dot   = dotted_q && (ts_q > ql5);
    trial3    = {2'b00, trial_q} + {1'b0, trial_q, 1'b0};
    bpm_eff   = (bpm_q == '0) ? tqr_pkg::BPM_W'(1) : bpm_q;
    q_sat     = tqr_pkg::sat_ql(div_rsp.quotient);
    sum_add   = {1'b0, sum_q} + (tqr_pkg::SUM_W + 1)'(q_sat);
    tempo_sat = (div_rsp.quotient > DW'(tqr_pkg::TEMPO_MAX)) ?
                tqr_pkg::TEMPO_MAX : div_rsp.quotient[tqr_pkg::TEMPO_W-1:0];
  end

  always_comb begin
    dotted_d  = dotted_q;
    auto_d    = auto_q;
    bpm_d     = bpm_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tqr_pkg::CFG_DOTTED: dotted_d = cfg_wdata_i[0];
        tqr_pkg::CFG_AUTO:   auto_d   = cfg_wdata_i[0];
        tqr_pkg::CFG_PRESET: bpm_d    = cfg_wdata_i[tqr_pkg::BPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    ql_d      = ql_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    ov_d      = ov_q;
    t_d       = t_q;
    first_d   = first_q;
    ts_d      = ts_q;
    trial_d   = trial_q;
    k_d       = k_q;
    dur_d     = dur_q;
    tempo_d   = tempo_q;
    o_dur_d   = o_dur_q;
    o_ql_d    = o_ql_q;
    o_tempo_d = o_tempo_q;
    div_req   = '0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      tqr_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          t_d     = T_W'(in_i.interval_ms) << FRAC_BITS;
          first_d = in_i.first_of_take;
          state_d = tqr_pkg::ST_SETUP;
        end
      end
      tqr_pkg::ST_SETUP: begin
        ts_d    = CMP_W'(t_q) << 1;
        trial_d = tqr_pkg::DUR_WHOLE;
        k_d     = '0;
        state_d = tqr_pkg::ST_CLASS;
        if (first_q || cnt_q == '0) begin
          sum_d = '0;
          cnt_d = '0;
          if (auto_q) begin
            ql_d = tqr_pkg::sat_ql(DW'(t_q));
          end else begin
            div_req.start    = 1'b1;
            div_req.nbits    = NB_NUM;
            div_req.dividend = TEMPO_NUM + DW'(bpm_eff >> 1);
            div_req.divisor  = tqr_pkg::QL_W'(bpm_eff);
            state_d          = tqr_pkg::ST_PRESET;
          end
        end
      end
      tqr_pkg::ST_PRESET: begin
        if (div_rsp.done) begin
          ql_d    = q_sat;
          state_d = tqr_pkg::ST_CLASS;
        end
      end
      tqr_pkg::ST_CLASS: begin
        if (hit_plain || hit_dot || k_q == tqr_pkg::CLASS_LAST) begin
          if (hit_plain) begin
            dur_d = trial_q;
          end else if (hit_dot) begin
            dur_d = trial3[tqr_pkg::DUR_W+1:2];
          end else begin
            dur_d = tqr_pkg::DUR_MIN;
          end
          state_d = (cnt_q < CNT_MAX) ? tqr_pkg::ST_SAMPLE_GO : tqr_pkg::ST_TEMPO_GO;
        end else begin
          ts_d    = ts_q << 1;
          trial_d = trial_q >> 1;
          k_d     = k_q + 3'd1;
        end
      end
      tqr_pkg::ST_SAMPLE_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = NB_SAMPLE;
        div_req.dividend = (DW'(t_q) << 7) - (DW'(t_q) << 3) + DW'(dur_q >> 1);
        div_req.divisor  = tqr_pkg::QL_W'(dur_q);
        state_d          = tqr_pkg::ST_SAMPLE;
      end
      tqr_pkg::ST_SAMPLE: begin
        if (div_rsp.done) begin
          sum_d   = sum_add[tqr_pkg::SUM_W] ? '1 : sum_add[tqr_pkg::SUM_W-1:0];
          cnt_d   = cnt_q + 1'b1;
          state_d = tqr_pkg::ST_MEAN_GO;
        end
      end
      tqr_pkg::ST_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = NB_MEAN;
        div_req.dividend = DW'(sum_q) + DW'(cnt_q >> 1);
        div_req.divisor  = tqr_pkg::QL_W'(cnt_q);
        state_d          = tqr_pkg::ST_MEAN;
      end
      tqr_pkg::ST_MEAN: begin
        if (div_rsp.done) begin
          ql_d    = q_sat;
          state_d = tqr_pkg::ST_TEMPO_GO;
        end
      end
      tqr_pkg::ST_TEMPO_GO: begin
        if (ql_q == '0) begin
          tempo_d = tqr_pkg::TEMPO_MAX;
          state_d = tqr_pkg::ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.nbits    = NB_NUM;
          div_req.dividend = TEMPO_NUM;
          div_req.divisor  = ql_q;
          state_d          = tqr_pkg::ST_TEMPO;
        end
      end
      tqr_pkg::ST_TEMPO: begin
        if (div_rsp.done) begin
          tempo_d = tempo_sat;
          state_d = tqr_pkg::ST_DONE;
        end
      end
      tqr_pkg::ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d      = 1'b1;
          o_dur_d   = dur_q;
          o_ql_d    = ql_q;
          o_tempo_d = tempo_q;
          state_d   = tqr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tqr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tqr_pkg::ST_IDLE;
      dotted_q <= 1'b0;
      auto_q   <= 1'b1;
      bpm_q    <= tqr_pkg::BPM_RESET;
      ql_q     <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      dotted_q <= dotted_d;
      auto_q   <= auto_d;
      bpm_q    <= bpm_d;
      ql_q     <= ql_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    first_q   <= first_d;
    ts_q      <= ts_d;
    trial_q   <= trial_d;
    k_q       <= k_d;
    dur_q     <= dur_d;
    tempo_q   <= tempo_d;
    o_dur_q   <= o_dur_d;
    o_ql_q    <= o_ql_d;
    o_tempo_q <= o_tempo_d;
  end

  assign in_i.ready                = (state_q == tqr_pkg::ST_IDLE);
  assign out_o.valid               = ov_q;
  assign out_o.duration_ticks      = o_dur_q;
  assign out_o.quarter_estimate_q8 = o_ql_q;
  assign out_o.tempo_bpm           = o_tempo_q;

endmodule

`default_nettype wire

FILE: sv/tqr_chk.sv
`default_nettype none

module tqr_chk (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_i,
  input wire                              out_valid_i,
  input wire                              out_ready_i,
  input wire [tqr_pkg::DUR_W-1:0]         dur_i,
  input wire [tqr_pkg::QL_W-1:0]          ql_i,
  input wire [tqr_pkg::TEMPO_W-1:0]       tempo_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dur_i) && $stable(ql_i)
      && $stable(tempo_i))
    else $error("result word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted again right after an accept");

  a_dur_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> dur_i == 9'd480 || dur_i == 9'd240 || dur_i == 9'd120 ||
      dur_i == 9'd60 || dur_i == 9'd30 || dur_i == 9'd15 || dur_i == 9'd360 ||
      dur_i == 9'd180 || dur_i == 9'd90 || dur_i == 9'd45 || dur_i == 9'd22 ||
      dur_i == 9'd11)
    else $error("duration is not a note value");

  a_zero_tempo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ql_i == '0 |-> tempo_i == tqr_pkg::TEMPO_MAX)
    else $error("zero quarter estimate without saturated tempo");

endmodule

bind tap_rhythm_quantizer tqr_chk u_tqr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dur_i       (out_o.duration_ticks),
  .ql_i        (out_o.quarter_estimate_q8),
  .tempo_i     (out_o.tempo_bpm)
);

`default_nettype wire
